// ===== hdl/poisson_residual_3d_stencil_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3D Poisson residual stencil
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef POISSON_RESIDUAL_3D_STENCIL_MACROS_SVH
`define POISSON_RESIDUAL_3D_STENCIL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PRS3_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PRS3_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/prs3_pkg.sv =====
// ----------------------------------------------------------------------------
// prs3_pkg
// Constants, the queued request type and the back-end state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prs3_pkg;

    // Largest supported cube edge; the phi store depth must stay a power of two.
    localparam int MAX_EDGE   = 64;
    localparam int EDGE_W     = 7;
    localparam int EDGE_MIN   = 3;
    localparam int EDGE_RESET = 18;
    localparam int LIN_W      = 18;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 64;

    localparam int PHI_DEPTH  = 2 * MAX_EDGE * MAX_EDGE;
    localparam int PHI_AW     = $clog2(PHI_DEPTH);
    localparam int SRC_DEPTH  = MAX_EDGE * MAX_EDGE + MAX_EDGE;
    localparam int SRC_AW     = $clog2(SRC_DEPTH);
    localparam int AREA_W     = $clog2(MAX_EDGE * MAX_EDGE + 1);

    localparam int PHI_READS  = 6;
    localparam int K_W        = 3;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_W  = 64;
    localparam int OUT_W = 88;

    // One classified sample on its way from the front end to the back end.
    typedef struct packed {
        logic [DATA_W-1:0] phi;
        logic [DATA_W-1:0] src;
        logic [LIN_W-1:0]  lin;
        logic [LIN_W-1:0]  point;
        logic [SRC_AW-1:0] src_waddr;
        logic [SRC_AW-1:0] src_raddr;
        logic [EDGE_W-1:0] edge_len;
        logic [AREA_W-1:0] area;
        logic              interior;
        logic              last;
    } prs3_item_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_READ,
        BK_COLLECT,
        BK_CALC,
        BK_SQUARE,
        BK_ACCUM,
        BK_EMIT,
        BK_STORE,
        BK_ROOT,
        BK_NORM
    } prs3_back_state_t;

endpackage

`default_nettype wire

// ===== hdl/poisson_residual_3d_stencil.sv =====
// ----------------------------------------------------------------------------
// poisson_residual_3d_stencil
// Seven-point Laplacian residual and residual norm over a streamed cube.
// ----------------------------------------------------------------------------
//
//   channel   direction   payload (low bits first)
//   -------   ---------   ------------------------------------------------
//   s_*       in          tdata: phi_value[31:0], source_value[63:32]
//   m_*       out         tdata: residual[31:0], point_index[49:32],
//                                norm[81:50], zero pad; tlast: is_final
//   cfg_*     in          data: grid_edge[6:0]
//
// A boundary sample only passes through the store step in the back end; an
// interior sample first takes six reads of the single-port phi store, then
// residual, square and accumulate steps and the load of the result register.
// After the grid's final sample the back end takes the bit-pair square root of
// the 64-bit sum of squares and loads the norm into the result register.
// The front end queues up to two requests, so input is taken while the back
// end works or a result waits in the output register.
// Reset (rst_n, asynchronous, active low) sets the edge to 18 and clears the
// position and the sum; the stores need no clearing pass.
// A configuration write restarts the grid. It is accepted in any cycle, so it
// must only be issued while no request is in flight.
//
`timescale 1ns / 1ps
`default_nettype none

module poisson_residual_3d_stencil
    import prs3_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration write: grid_edge
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [EDGE_W-1:0] cfg_data,
    // Input requests: phi_value[31:0], source_value[63:32]
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,
    // Results: residual[31:0], point_index[49:32], norm[81:50]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,
    // is_final
    output logic                   m_tlast
);

    logic       q_full, q_push, q_pop, q_valid, restart;
    prs3_item_t push_item, pop_item;

    // The front end keeps the raster position and classifies each sample.
    prs3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item),
        .restart   (restart)
    );

    prs3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    // The back end owns both stores, the running sum and the result register.
    prs3_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (pop_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hdl/prs3_ram.sv =====
// ----------------------------------------------------------------------------
// prs3_ram
// Single-port RAM with registered read data (read before write).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prs3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[addr];
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/prs3_front.sv =====
// ----------------------------------------------------------------------------
// prs3_front
// Tracks the raster position, classifies each sample and queues it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prs3_front
    import prs3_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [EDGE_W-1:0] cfg_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,
    input  wire logic              q_full,
    output logic                   q_push,
    output prs3_item_t             q_item,
    output logic                   restart
);

    logic [EDGE_W-1:0] edge_reg, edge_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [EDGE_W-1:0] x_reg, y_reg, z_reg;
    logic [LIN_W-1:0]  lin_reg;
    logic [SRC_AW-1:0] srcw_reg;
    logic [2*EDGE_W-1:0] area_full;
    logic [EDGE_W-1:0] e_m1, e_m2;
    logic              x_end, y_end;
    logic [SRC_AW:0]   src_diff;

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid;
    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;

    always_comb
    begin
        if (cfg_data < EDGE_W'(EDGE_MIN))
            edge_next = EDGE_W'(EDGE_MIN);
        else if (cfg_data > EDGE_W'(MAX_EDGE))
            edge_next = EDGE_W'(MAX_EDGE);
        else
            edge_next = cfg_data;
        area_full = edge_next * edge_next;
        area_next = area_full[AREA_W-1:0];
    end

    assign e_m1  = edge_reg - EDGE_W'(1);
    assign e_m2  = edge_reg - EDGE_W'(2);
    assign x_end = (x_reg == e_m1);
    assign y_end = (y_reg == e_m1);

    // The point being completed lies one plane behind; its source entry is
    // one plane back in the circular delay store.
    assign src_diff = {1'b0, srcw_reg} - (SRC_AW+1)'(area_reg);

    always_comb
    begin
        q_item.phi       = s_tdata[DATA_W-1:0];
        q_item.src       = s_tdata[2*DATA_W-1:DATA_W];
        q_item.lin       = lin_reg;
        q_item.point     = lin_reg - LIN_W'(area_reg);
        q_item.src_waddr = srcw_reg;
        q_item.src_raddr = src_diff[SRC_AW] ?
                           SRC_AW'(src_diff + (SRC_AW+1)'(SRC_DEPTH)) :
                           src_diff[SRC_AW-1:0];
        q_item.edge_len  = edge_reg;
        q_item.area      = area_reg;
        q_item.interior  = (z_reg >= EDGE_W'(2)) && (x_reg != '0) && (x_reg <= e_m2) &&
                           (y_reg != '0) && (y_reg <= e_m2);
        q_item.last      = x_end && y_end && (z_reg == e_m1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg <= EDGE_W'(EDGE_RESET);
            area_reg <= AREA_W'(EDGE_RESET * EDGE_RESET);
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            lin_reg  <= '0;
            srcw_reg <= '0;
        end
        else if (cfg_valid)
        begin
            edge_reg <= edge_next;
            area_reg <= area_next;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            lin_reg  <= '0;
            srcw_reg <= '0;
        end
        else if (q_push)
        begin
            if (q_item.last)
            begin
                x_reg    <= '0;
                y_reg    <= '0;
                z_reg    <= '0;
                lin_reg  <= '0;
                srcw_reg <= '0;
            end
            else
            begin
                lin_reg  <= lin_reg + LIN_W'(1);
                srcw_reg <= (srcw_reg == SRC_AW'(SRC_DEPTH - 1)) ? '0 :
                            srcw_reg + SRC_AW'(1);
                if (x_end)
                begin
                    x_reg <= '0;
                    if (y_end)
                    begin
                        y_reg <= '0;
                        z_reg <= z_reg + EDGE_W'(1);
                    end
                    else
                    begin
                        y_reg <= y_reg + EDGE_W'(1);
                    end
                end
                else
                begin
                    x_reg <= x_reg + EDGE_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/prs3_queue.sv =====
// ----------------------------------------------------------------------------
// prs3_queue
// Short request queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "poisson_residual_3d_stencil_macros.svh"

module prs3_queue
    import prs3_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  prs3_item_t      push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output prs3_item_t      pop_item
);

    prs3_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + QPTR_W'(1);
            if (pop)
                rptr_reg <= rptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    `PRS3_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full)
    `PRS3_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, not_empty)
    `PRS3_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, not_empty)

endmodule

`default_nettype wire

// ===== hdl/prs3_back.sv =====
// ----------------------------------------------------------------------------
// prs3_back
// Gathers the stencil, forms and squares the residual, keeps the sum of
// squares, takes its root at the end of a grid and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "poisson_residual_3d_stencil_macros.svh"

module prs3_back
    import prs3_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             restart,
    input  wire logic             q_valid,
    output logic                  q_pop,
    input  prs3_item_t            q_item,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast
);

    prs3_back_state_t state_reg, state_next;
    prs3_item_t       cur_reg;
    logic [K_W-1:0]   k_reg;
    logic signed [DATA_W-1:0] centre_reg, src_reg, resid_reg;
    logic signed [DATA_W+2:0] nsum_reg;
    logic [SUM_W-1:0] sq_reg, sum_reg, rem_reg, root_reg, bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic             out_valid_reg, out_last_reg;
    logic [DATA_W-1:0] out_resid_reg, out_norm_reg;
    logic [LIN_W-1:0] out_point_reg;

    logic [PHI_AW-1:0] phi_addr, p_a, e_a, ar_a;
    logic              phi_we, src_we;
    logic [SRC_AW-1:0] src_addr;
    logic [DATA_W-1:0] phi_rdata, src_rdata;
    logic              out_free;
    logic signed [DATA_W+5:0] six_c, lap, r_full;
    logic signed [DATA_W-1:0] r_sat;
    logic [DATA_W:0]   neg_r;
    logic [DATA_W-1:0] mag;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  root_try;

    prs3_ram #(.WIDTH(DATA_W), .DEPTH(PHI_DEPTH)) u_phi_ram (
        .clk   (clk),
        .we    (phi_we),
        .addr  (phi_addr),
        .wdata (cur_reg.phi),
        .rdata (phi_rdata)
    );

    prs3_ram #(.WIDTH(DATA_W), .DEPTH(SRC_DEPTH)) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .addr  (src_addr),
        .wdata (cur_reg.src),
        .rdata (src_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign p_a      = cur_reg.point[PHI_AW-1:0];
    assign e_a      = PHI_AW'(cur_reg.edge_len);
    assign ar_a     = PHI_AW'(cur_reg.area);

    // Residual from the gathered centre, neighbour sum and delayed source.
    always_comb
    begin
        six_c  = ({{6{centre_reg[DATA_W-1]}}, centre_reg} <<< 2) +
                 ({{6{centre_reg[DATA_W-1]}}, centre_reg} <<< 1);
        lap    = six_c - {{3{nsum_reg[DATA_W+2]}}, nsum_reg};
        r_full = {{6{src_reg[DATA_W-1]}}, src_reg} - lap;
        if (r_full > (DATA_W+6)'(signed'(32'h7fffffff)))
            r_sat = 32'sh7fffffff;
        else if (r_full < -(DATA_W+6)'(64'sh80000000))
            r_sat = 32'sh80000000;
        else
            r_sat = r_full[DATA_W-1:0];
        neg_r   = (DATA_W+1)'(0) - {resid_reg[DATA_W-1], resid_reg};
        mag     = resid_reg[DATA_W-1] ? neg_r[DATA_W-1:0] : resid_reg;
        sum_add = {1'b0, sum_reg} + {1'b0, sq_reg};
        root_try = root_reg + bit_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (q_valid)
                    state_next = q_item.interior ? BK_READ : BK_STORE;
            BK_READ:
                if (k_reg == K_W'(PHI_READS - 1))
                    state_next = BK_COLLECT;
            BK_COLLECT: state_next = BK_CALC;
            BK_CALC:    state_next = BK_SQUARE;
            BK_SQUARE:  state_next = BK_ACCUM;
            BK_ACCUM:   state_next = BK_EMIT;
            BK_EMIT:
                if (out_free)
                    state_next = BK_IDLE;
            BK_STORE:
                state_next = cur_reg.last ? BK_ROOT : BK_IDLE;
            BK_ROOT:
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    state_next = BK_NORM;
            BK_NORM:
                if (out_free)
                    state_next = BK_IDLE;
            default:    state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        phi_we   = 1'b0;
        src_we   = 1'b0;
        phi_addr = cur_reg.lin[PHI_AW-1:0];
        src_addr = cur_reg.src_waddr;
        unique case (state_reg)
            BK_IDLE:
                q_pop = q_valid;
            BK_READ:
            begin
                src_addr = cur_reg.src_raddr;
                case (k_reg)
                    K_W'(0): phi_addr = p_a;
                    K_W'(1): phi_addr = p_a - PHI_AW'(1);
                    K_W'(2): phi_addr = p_a + PHI_AW'(1);
                    K_W'(3): phi_addr = p_a - e_a;
                    K_W'(4): phi_addr = p_a + e_a;
                    default: phi_addr = p_a - ar_a;
                endcase
            end
            BK_CALC, BK_STORE:
            begin
                phi_we = 1'b1;
                src_we = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == BK_ACCUM)
                sum_reg <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (out_free && (state_reg == BK_EMIT || state_reg == BK_NORM))
                out_valid_reg <= 1'b1;
            if (out_free && state_reg == BK_NORM)
                sum_reg <= '0;
            if (restart)
                sum_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                cur_reg  <= q_item;
                k_reg    <= '0;
                nsum_reg <= {{3{q_item.phi[DATA_W-1]}}, q_item.phi};
            end
            BK_READ:
            begin
                k_reg <= k_reg + K_W'(1);
                if (k_reg == K_W'(1))
                begin
                    centre_reg <= phi_rdata;
                    src_reg    <= src_rdata;
                end
                else if (k_reg != '0)
                begin
                    nsum_reg <= nsum_reg + {{3{phi_rdata[DATA_W-1]}}, phi_rdata};
                end
            end
            BK_COLLECT:
                nsum_reg <= nsum_reg + {{3{phi_rdata[DATA_W-1]}}, phi_rdata};
            BK_CALC:
                resid_reg <= r_sat;
            BK_SQUARE:
                sq_reg <= mag * mag;
            BK_EMIT:
                if (out_free)
                begin
                    out_resid_reg <= resid_reg;
                    out_point_reg <= cur_reg.point;
                    out_norm_reg  <= '0;
                    out_last_reg  <= 1'b0;
                end
            BK_STORE:
            begin
                rem_reg  <= sum_reg;
                root_reg <= '0;
                bit_reg  <= SUM_W'(1) << (SUM_W - 2);
                step_reg <= '0;
            end
            BK_ROOT:
            begin
                step_reg <= step_reg + STEP_W'(1);
                bit_reg  <= bit_reg >> 2;
                if (rem_reg >= root_try)
                begin
                    rem_reg  <= rem_reg - root_try;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            BK_NORM:
                if (out_free)
                begin
                    out_resid_reg <= '0;
                    out_point_reg <= '0;
                    out_norm_reg  <= root_reg[DATA_W-1:0];
                    out_last_reg  <= 1'b1;
                end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(OUT_W - 2*DATA_W - LIN_W)'(0), out_norm_reg, out_point_reg,
                       out_resid_reg};

    `PRS3_ASSERT_NEXT(a_read_ends, clk, rst_n,
        state_reg == BK_READ && k_reg == K_W'(PHI_READS - 1), state_reg == BK_COLLECT)
    `PRS3_ASSERT_NEXT(a_norm_marked, clk, rst_n,
        state_reg == BK_NORM && out_free, m_tvalid && m_tlast)
    `PRS3_ASSERT_NEXT(a_sum_cleared, clk, rst_n,
        state_reg == BK_NORM && out_free, sum_reg == '0)
    `PRS3_ASSERT_NOW(a_pop_idle, clk, rst_n, q_pop, state_reg == BK_IDLE)

endmodule

`default_nettype wire
